[src/plbb_pkg.sv]
// ----------------------------------------------------------------------------
// plbb_pkg
// Shared types and constants for the point list bounding box block.
// ----------------------------------------------------------------------------
package plbb_pkg;

  localparam int COORD_W        = 32;
  localparam int IDX_W          = 4;
  localparam int CNT_OUT_W      = 5;
  localparam int DEF_MAX_POINTS = 16;

  localparam logic signed [COORD_W-1:0] COORD_TOP    = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_BOTTOM = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t                   req_type;
    logic signed [COORD_W-1:0]   x_coord;
    logic signed [COORD_W-1:0]   y_coord;
    logic [IDX_W-1:0]            point_index;
  } in_item_t;

  typedef struct packed {
    logic                        ok;
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic signed [COORD_W-1:0]   box_min_x;
    logic signed [COORD_W-1:0]   box_min_y;
    logic signed [COORD_W-1:0]   box_max_x;
    logic signed [COORD_W-1:0]   box_max_y;
    logic [CNT_OUT_W-1:0]        point_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]   least_x;
    logic signed [COORD_W-1:0]   least_y;
    logic signed [COORD_W-1:0]   greatest_x;
    logic signed [COORD_W-1:0]   greatest_y;
  } box_t;

  localparam box_t BOX_EMPTY = '{
    least_x:    COORD_TOP,
    least_y:    COORD_TOP,
    greatest_x: COORD_BOTTOM,
    greatest_y: COORD_BOTTOM
  };

endpackage

[src/plbb_ram.sv]
// ----------------------------------------------------------------------------
// plbb_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module plbb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/plbb_box.sv]
// ----------------------------------------------------------------------------
// plbb_box
// Running bounding box: clears to empty extremes, widens by one point a cycle.
// ----------------------------------------------------------------------------
module plbb_box (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear,
  input  logic                                widen,
  input  logic signed [plbb_pkg::COORD_W-1:0] x,
  input  logic signed [plbb_pkg::COORD_W-1:0] y,
  output plbb_pkg::box_t                      box
);
  import plbb_pkg::*;

  box_t box_r;
  box_t box_nxt;

  always_comb begin
    box_nxt = box_r;
    if (clear) begin
      box_nxt = BOX_EMPTY;
    end else if (widen) begin
      if (x > box_r.greatest_x) box_nxt.greatest_x = x;
      if (y > box_r.greatest_y) box_nxt.greatest_y = y;
      if (x < box_r.least_x)    box_nxt.least_x    = x;
      if (y < box_r.least_y)    box_nxt.least_y    = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_EMPTY;
    end else begin
      box_r <= box_nxt;
    end
  end

  assign box = box_r;

`ifndef SYNTHESIS
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (box_r == BOX_EMPTY))
    else $error("box not empty after clear");
`endif

endmodule

[src/point_list_bounding_box.sv]
// ----------------------------------------------------------------------------
// point_list_bounding_box
// Ordered point list in RAM with a running bounding box.
// ----------------------------------------------------------------------------
//  channel  dir  ports                          item
//  in       in   in_valid, in_stall, in_data    request (add/remove/read/query)
//  out      out  out_valid, out_stall, out_data one result per request
//
//  Add, query and failed requests: accept, then ST_DONE with the result in res_r.
//  Read: accept, ST_RDATA (one RAM read), then ST_DONE.
//  Remove: accept, ST_SCAN, then ST_DONE; one RAM pass reads every entry once,
//  writing entries above the index one slot down and rebuilding the box.
//  One item at a time; in_stall is high from accept until the result is
//  loaded into the output register, which holds it while out_stall is high.
//  Reset empties the list and the box; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module point_list_bounding_box #(
  parameter int MAX_POINTS = plbb_pkg::DEF_MAX_POINTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plbb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plbb_pkg::out_item_t out_data
);
  import plbb_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDATA,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t          state_r,    state_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [CNT_W-1:0] scan_r,    scan_nxt;
  logic            rd_vld_r,   rd_vld_nxt;
  logic [AW-1:0]   rd_addr_d_r, rd_addr_d_nxt;
  in_item_t        req_r,      req_nxt;
  out_item_t       res_r,      res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic                      in_acc;
  logic                      idx_ok;
  logic [AW-1:0]             idx_a;
  logic [AW-1:0]             rmv_idx;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [2*COORD_W-1:0]      mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [2*COORD_W-1:0]      mem_rdata;
  logic                      box_clear;
  logic                      box_widen;
  logic signed [COORD_W-1:0] box_x;
  logic signed [COORD_W-1:0] box_y;
  box_t                      box;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign idx_a    = AW'(in_data.point_index);
  assign rmv_idx  = AW'(req_r.point_index);
  assign idx_ok   = (32'(in_data.point_index) < 32'(count_r)) &&
                    (32'(in_data.point_index) < MAX_POINTS);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    rd_vld_nxt    = 1'b0;
    rd_addr_d_nxt = rd_addr_d_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = {in_data.x_coord, in_data.y_coord};
    mem_raddr     = idx_a;
    box_clear     = 1'b0;
    box_widen     = 1'b0;
    box_x         = in_data.x_coord;
    box_y         = in_data.y_coord;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          state_nxt = ST_DONE;
          unique case (in_data.req_type)
            REQ_ADD: begin
              if (32'(count_r) < MAX_POINTS) begin
                mem_we     = 1'b1;
                box_widen  = 1'b1;
                count_nxt  = count_r + 1'b1;
                res_nxt.ok = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (idx_ok) begin
                box_clear = 1'b1;
                scan_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            REQ_READ: begin
              if (idx_ok) begin
                state_nxt = ST_RDATA;
              end
            end
            REQ_QUERY: begin
              if (32'(count_r) >= 2) begin
                res_nxt.ok        = 1'b1;
                res_nxt.box_min_x = box.least_x;
                res_nxt.box_min_y = box.least_y;
                res_nxt.box_max_x = box.greatest_x;
                res_nxt.box_max_y = box.greatest_y;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RDATA: begin
        res_nxt.ok      = 1'b1;
        res_nxt.point_x = mem_rdata[2*COORD_W-1:COORD_W];
        res_nxt.point_y = mem_rdata[COORD_W-1:0];
        state_nxt       = ST_DONE;
      end
      ST_SCAN: begin
        if (rd_vld_r) begin
          box_x = mem_rdata[2*COORD_W-1:COORD_W];
          box_y = mem_rdata[COORD_W-1:0];
          if (rd_addr_d_r != rmv_idx) begin
            box_widen = 1'b1;
          end
          if (rd_addr_d_r > rmv_idx) begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_d_r - 1'b1;
            mem_wdata = mem_rdata;
          end
        end
        if (scan_r < count_r) begin
          mem_raddr     = scan_r[AW-1:0];
          rd_vld_nxt    = 1'b1;
          rd_addr_d_nxt = scan_r[AW-1:0];
          scan_nxt      = scan_r + 1'b1;
        end else if (!rd_vld_r) begin
          count_nxt  = count_r - 1'b1;
          res_nxt.ok = 1'b1;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = res_r;
          out_data_nxt.point_count = CNT_OUT_W'(count_r);
          state_nxt                = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_d_r <= rd_addr_d_nxt;
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  plbb_ram #(
    .WIDTH (2*COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  plbb_box u_box (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (box_clear),
    .widen (box_widen),
    .x     (box_x),
    .y     (box_y),
    .box   (box)
  );

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_POINTS)
    else $error("point count above capacity");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mem_we) |-> (32'(mem_waddr) < 32'(scan_r)))
    else $error("shift write not below scan read");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count_r == '0) |-> (box == BOX_EMPTY))
    else $error("box not empty with no points");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count_r != '0) |->
      (box.least_x <= box.greatest_x && box.least_y <= box.greatest_y))
    else $error("box extremes out of order");
`endif

endmodule
